@@ hdl/dmm_pkg.sv @@
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types and constants of the dense matrix multiply core.
// ----------------------------------------------------------------------------
package dmm_pkg;

    // span of the 4-bit index fields
    localparam int FIELD_SPAN = 16;

    localparam logic [1:0] MODE_WR_A    = 2'd0;
    localparam logic [1:0] MODE_WR_B    = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;

    localparam logic [4:0] SIZE_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
        logic signed [15:0] element_value;
    } t_dmm_in;

    typedef struct packed {
        logic [3:0]         out_row;
        logic [3:0]         out_col;
        logic signed [35:0] product_value;
        logic               last;
    } t_dmm_out;

    // controller to datapath
    typedef struct packed {
        logic       wr_a;
        logic       wr_b;
        logic       rd_en;
        logic       first;
        logic       last_k;
        logic       last_col;
        logic [3:0] row;
        logic [3:0] col;
        logic [3:0] k;
    } t_dmm_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_valid;
        logic col_done;
    } t_dmm_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT_OUT,
        ST_ISSUE,
        ST_DRAIN
    } t_dmm_state;

endpackage

@@ hdl/dmm_ctrl.sv @@
// ----------------------------------------------------------------------------
// dmm_ctrl
// Sequencer: takes requests, holds the size register, steps columns and k.
// ----------------------------------------------------------------------------
module dmm_ctrl
    import dmm_pkg::*;
#(
    parameter int MAX_SIZE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  t_dmm_in     i_in_data,
    output logic        o_in_ready,
    input  t_dmm_status i_status,
    output t_dmm_cmd    o_cmd
);

    localparam int DIM = (MAX_SIZE < FIELD_SPAN) ? MAX_SIZE : FIELD_SPAN;

    t_dmm_state r_state, n_state;
    logic [4:0] r_matrix_size;
    logic [4:0] r_n, n_n;
    logic [3:0] r_row, n_row;
    logic [3:0] r_col, n_col;
    logic [3:0] r_k, n_k;
    logic [4:0] size_use;
    logic       wr_in_range;
    logic [3:0] n_last;

    assign size_use    = (r_matrix_size > 5'(DIM)) ? 5'(DIM) : r_matrix_size;
    assign wr_in_range = ({1'b0, i_in_data.row_index} < 5'(DIM))
                      && ({1'b0, i_in_data.col_index} < 5'(DIM));
    assign n_last      = 4'(r_n - 5'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_matrix_size <= SIZE_RESET;
            r_n           <= '0;
            r_row         <= '0;
            r_col         <= '0;
            r_k           <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
            if (i_cfg_we) begin
                r_matrix_size <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_row      = r_row;
        n_col      = r_col;
        n_k        = r_k;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.row  = r_row;
        o_cmd.col  = r_col;
        o_cmd.k    = r_k;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_data.mode)
                        MODE_WR_A: o_cmd.wr_a = wr_in_range;
                        MODE_WR_B: o_cmd.wr_b = wr_in_range;
                        MODE_COMPUTE: begin
                            // rows beyond the size in use give nothing
                            if ({1'b0, i_in_data.row_index} < size_use) begin
                                n_row   = i_in_data.row_index;
                                n_n     = size_use;
                                n_col   = '0;
                                n_state = ST_WAIT_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WAIT_OUT: begin
                // result lands straight in the output register
                if (!i_status.out_valid) begin
                    n_k     = '0;
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.first    = (r_k == 4'd0);
                o_cmd.last_k   = (r_k == n_last);
                o_cmd.last_col = (r_col == n_last);
                if (r_k == n_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            ST_DRAIN: begin
                if (i_status.col_done) begin
                    if (r_col == n_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_col   = r_col + 4'd1;
                        n_state = ST_WAIT_OUT;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ hdl/dmm_datapath.sv @@
// ----------------------------------------------------------------------------
// dmm_datapath
// Element stores for A and B, pipelined multiply-accumulate, output register.
// ----------------------------------------------------------------------------
module dmm_datapath
    import dmm_pkg::*;
#(
    parameter int MAX_SIZE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dmm_cmd    i_cmd,
    input  t_dmm_in     i_in_data,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output t_dmm_out    o_out_data,
    output t_dmm_status o_status
);

    localparam int DIM   = (MAX_SIZE < FIELD_SPAN) ? MAX_SIZE : FIELD_SPAN;
    localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int AW    = (DIM > 1) ? $clog2(DIM * DIM) : 1;
    localparam int DEPTH = DIM * DIM;

    logic signed [15:0] mem_a [DEPTH];
    logic signed [15:0] mem_b [DEPTH];

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;

    // stage 1: read data
    logic signed [15:0] r_a_q, r_b_q;
    logic               r_v1, r_first1, r_lastk1, r_lastc1;
    logic [3:0]         r_col1;
    // stage 2: product
    logic signed [31:0] r_prod;
    logic               r_v2, r_first2, r_lastk2, r_lastc2;
    logic [3:0]         r_col2;
    // stage 3: accumulate
    logic signed [35:0] r_acc;
    logic signed [35:0] sum;
    logic               r_out_valid;
    t_dmm_out           r_out;

    assign wr_addr   = AW'(i_in_data.row_index[IW-1:0]) * AW'(DIM)
                     + AW'(i_in_data.col_index[IW-1:0]);
    assign rd_addr_a = AW'(i_cmd.row[IW-1:0]) * AW'(DIM) + AW'(i_cmd.k[IW-1:0]);
    assign rd_addr_b = AW'(i_cmd.k[IW-1:0]) * AW'(DIM) + AW'(i_cmd.col[IW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            mem_a[wr_addr] <= i_in_data.element_value;
        end
        if (i_cmd.rd_en) begin
            r_a_q <= mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            mem_b[wr_addr] <= i_in_data.element_value;
        end
        if (i_cmd.rd_en) begin
            r_b_q <= mem_b[rd_addr_b];
        end
    end

    assign sum = r_first2 ? 36'(r_prod) : r_acc + 36'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            if (r_v2 && r_lastk2) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= i_cmd.first;
        r_lastk1 <= i_cmd.last_k;
        r_lastc1 <= i_cmd.last_col;
        r_col1   <= i_cmd.col;
        r_prod   <= r_a_q * r_b_q;
        r_first2 <= r_first1;
        r_lastk2 <= r_lastk1;
        r_lastc2 <= r_lastc1;
        r_col2   <= r_col1;
        if (r_v2) begin
            r_acc <= sum;
        end
        if (r_v2 && r_lastk2) begin
            r_out.out_row       <= i_cmd.row;
            r_out.out_col       <= r_col2;
            r_out.product_value <= sum;
            r_out.last          <= r_lastc2;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;
    assign o_status.out_valid = r_out_valid;
    assign o_status.col_done  = r_v2 && r_lastk2;

endmodule

@@ hdl/dense_matrix_multiply_core.sv @@
// ----------------------------------------------------------------------------
// dense_matrix_multiply_core
// C = A x B on signed 16-bit elements, one row of C per compute request.
//
//   channel   direction   handshake                  payload
//   config    in          i_cfg_we                   i_cfg_data (matrix_size)
//   request   in          i_in_valid / o_in_ready    i_in_data  (t_dmm_in)
//   result    out         o_out_valid / i_out_ready  o_out_data (t_dmm_out)
//
// a compute request of size n issues n reads per column from the A and B
// stores, feeding one shared multiply-accumulate, and lets the pipeline drain
// after each column.
// a column waits while the previous result is still held in the output register.
// synchronous active-low reset; store contents are not cleared.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_core
    import dmm_pkg::*;
#(
    parameter int MAX_SIZE = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dmm_in    i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dmm_out   o_out_data
);

    t_dmm_cmd    cmd;
    t_dmm_status status;

    dmm_ctrl #(
        .MAX_SIZE (MAX_SIZE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dmm_datapath #(
        .MAX_SIZE (MAX_SIZE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_status    (status)
    );

`ifndef SYNTHESIS
    // a finished column never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.col_done |-> !o_out_valid)
        else $error("result loaded while output register full");

    // requests are taken only while no column is being read
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !cmd.rd_en)
        else $error("request accepted during compute");

    // store writes never overlap compute reads
    a_no_wr_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_en |-> !(cmd.wr_a || cmd.wr_b))
        else $error("store write during compute read");

    // a column result appears in the output register the next cycle
    a_col_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.col_done |=> o_out_valid)
        else $error("column result not presented");
`endif

endmodule
